// ===== rtl/snc_pkg.sv =====
// Package for the smooth number checker: widths, register codes, reset values
// and the command and status types passed between the sequencer and the divider.
// Depends on nothing; every other file of the block uses it.
package snc_pkg;

   // Defaults for the top-level parameters.
   localparam int unsigned MAX_PRIMES_DEF = 6;
   localparam int unsigned VALUE_BITS_DEF = 32;

   // Fixed field widths.
   localparam int unsigned PRIME_REGS     = 6;
   localparam int unsigned PRIME_BITS     = 16;
   localparam int unsigned CNT_BITS       = 3;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned COUNT_BITS     = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIME_0     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIME_COUNT = 3'd6;

   // Reset values of the factor set and its length.
   localparam logic [PRIME_BITS-1:0] PRIME_RESET [PRIME_REGS] =
      '{16'd2, 16'd3, 16'd5, 16'd7, 16'd11, 16'd13};
   localparam logic [CNT_BITS-1:0] PRIME_COUNT_RESET = 3'd6;

   // Smallest set entry that is allowed to divide.
   localparam logic [PRIME_BITS-1:0] PRIME_MIN = 16'd2;

   // Start of one trial division.
   typedef struct packed {
      logic                  start;
      logic [PRIME_BITS-1:0] divisor;
   } snc_div_cmd_type;

   // Outcome of one trial division.
   typedef struct packed {
      logic done;
      logic exact;
   } snc_div_stat_type;

endpackage

// ===== rtl/snc_channels.sv =====
// Channel interfaces of the smooth number checker: input items, results and
// configuration writes. Depends on snc_pkg for default widths.

interface snc_req_if #(
   parameter int unsigned VALUE_BITS = snc_pkg::VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic                  restart_count;

   modport source (output valid, output value, output restart_count, input ready);
   modport sink   (input valid, input value, input restart_count, output ready);
endinterface

interface snc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            is_smooth;
   logic [snc_pkg::COUNT_BITS-1:0]  smooth_count;

   modport source (output valid, output is_smooth, output smooth_count, input ready);
   modport sink   (input valid, input is_smooth, input smooth_count, output ready);
endinterface

interface snc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [snc_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [snc_pkg::PRIME_BITS-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/snc_div.sv =====
// Bit-serial restoring divider: divides the residue by one set entry, one
// quotient bit per cycle. Depends on snc_pkg.
module snc_div #(
   parameter int unsigned VALUE_BITS = snc_pkg::VALUE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  snc_pkg::snc_div_cmd_type   cmd_i,
   input  logic [VALUE_BITS-1:0]      dividend_i,
   output snc_pkg::snc_div_stat_type  stat_o,
   output logic [VALUE_BITS-1:0]      quotient_o
);
   import snc_pkg::*;

   localparam int unsigned CNT_W = $clog2(VALUE_BITS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(VALUE_BITS - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [VALUE_BITS-1:0] quot_ff;
   logic [PRIME_BITS-1:0] rem_ff;
   logic [PRIME_BITS-1:0] div_ff;

   logic [PRIME_BITS:0]   shifted;
   logic [PRIME_BITS:0]   diff;
   logic                  fits;
   logic [PRIME_BITS-1:0] rem_in;

   // One restoring step: bring down the next dividend bit and try to subtract.
   always_comb begin
      shifted = {rem_ff, quot_ff[VALUE_BITS-1]};
      fits    = shifted >= {1'b0, div_ff};
      diff    = shifted - {1'b0, div_ff};
      rem_in  = fits ? diff[PRIME_BITS-1:0] : shifted[PRIME_BITS-1:0];
   end

   // The dividend shifts out at the top while quotient bits shift in below.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd_i.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quot_ff <= dividend_i;
            rem_ff  <= '0;
            div_ff  <= cmd_i.divisor;
         end else if (busy_ff) begin
            quot_ff <= {quot_ff[VALUE_BITS-2:0], fits};
            rem_ff  <= rem_in;
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat_o.done  = done_ff;
   assign stat_o.exact = (rem_ff == '0);
   assign quotient_o   = quot_ff;

endmodule

// ===== rtl/snc_csr.sv =====
// Configuration registers of the smooth number checker: the factor set and
// its length, with entry selection for the sequencer. Depends on snc_pkg and
// the snc_csr_if interface.
module snc_csr #(
   parameter int unsigned MAX_PRIMES = snc_pkg::MAX_PRIMES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   snc_csr_if.sink                         csr_if,
   input  logic [snc_pkg::CNT_BITS-1:0]    sel_i,
   output logic [snc_pkg::PRIME_BITS-1:0]  sel_prime_o,
   output logic [snc_pkg::CNT_BITS-1:0]    active_o
);
   import snc_pkg::*;

   // Entries beyond the usable count can never be read, so they are not kept.
   localparam int unsigned NREGS =
      (MAX_PRIMES < PRIME_REGS) ? MAX_PRIMES : PRIME_REGS;
   localparam logic [CNT_BITS-1:0] NREGS_CNT = CNT_BITS'(NREGS);

   logic [PRIME_BITS-1:0] prime_ff [NREGS];
   logic [CNT_BITS-1:0]   count_ff;

   // Writes are always taken; unknown indexes are dropped.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREGS; i++) begin
            prime_ff[i] <= PRIME_RESET[i];
         end
         count_ff <= PRIME_COUNT_RESET;
      end else if (csr_if.valid) begin
         for (int i = 0; i < NREGS; i++) begin
            if (csr_if.index == CSR_PRIME_0 + CSR_INDEX_BITS'(i)) begin
               prime_ff[i] <= csr_if.data;
            end
         end
         if (csr_if.index == CSR_PRIME_COUNT) begin
            count_ff <= csr_if.data[CNT_BITS-1:0];
         end
      end
   end

   // A count above the number of usable entries is clamped.
   assign active_o = (count_ff > NREGS_CNT) ? NREGS_CNT : count_ff;

   // Entry selected by the sequencer.
   always_comb begin
      sel_prime_o = '0;
      for (int i = 0; i < NREGS; i++) begin
         if (sel_i == CNT_BITS'(i)) begin
            sel_prime_o = prime_ff[i];
         end
      end
   end

endmodule

// ===== rtl/smooth_number_checker_unit.sv =====
// Top level of the smooth number checker: sequencer, result register and
// running count. Depends on snc_pkg, snc_channels, snc_csr and snc_div.
//
//   Channel  Direction  Beat carries
//   req_if   in         value, restart_count
//   rsp_if   out        is_smooth, smooth_count
//   csr_if   in         index, data (prime_0..prime_5, prime_count)
//
// One item at a time; each trial division is bit-serial. An item passes through S_CHECK,
// then S_TRY for each entry in use, skipping entries below two, and S_DIV for each trial;
// a factor divided out returns it to S_CHECK, which starts the set over; it ends in S_FINISH.
// Reset is synchronous and active high; the register file returns to its reset values
// and the running count to zero. A stalled result waits in the output register while
// the next item is accepted and worked on.
module smooth_number_checker_unit #(
   parameter int unsigned MAX_PRIMES = snc_pkg::MAX_PRIMES_DEF,
   parameter int unsigned VALUE_BITS = snc_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   snc_req_if.sink     req_if,
   snc_rsp_if.source   rsp_if,
   snc_csr_if.sink     csr_if
);
   import snc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_TRY,
      S_DIV,
      S_FINISH
   } state_type;

   state_type             state_ff;
   logic [VALUE_BITS-1:0] resid_ff;
   logic [CNT_BITS-1:0]   idx_ff;
   logic                  smooth_ff;
   logic [COUNT_BITS-1:0] total_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_smooth_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   logic [PRIME_BITS-1:0] sel_prime;
   logic [CNT_BITS-1:0]   active;
   snc_div_cmd_type       div_cmd;
   snc_div_stat_type      div_stat;
   logic [VALUE_BITS-1:0] quotient;
   logic                  slot_free;
   logic                  rsp_load;
   logic [COUNT_BITS-1:0] total_in;

   snc_csr #(
      .MAX_PRIMES (MAX_PRIMES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_if      (csr_if),
      .sel_i       (idx_ff),
      .sel_prime_o (sel_prime),
      .active_o    (active)
   );

   snc_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .cmd_i      (div_cmd),
      .dividend_i (resid_ff),
      .stat_o     (div_stat),
      .quotient_o (quotient)
   );

   // A trial starts when the selected entry is in use and may divide.
   always_comb begin
      div_cmd.start   = (state_ff == S_TRY) && (idx_ff < active) && (sel_prime >= PRIME_MIN);
      div_cmd.divisor = sel_prime;
   end

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   // The finished item moves into the output register once that register is free.
   assign rsp_load = (state_ff == S_FINISH) && slot_free;

   // Saturating count including the finished item when it is smooth.
   assign total_in = (smooth_ff && (total_ff != '1)) ? total_ff + 1'b1 : total_ff;

   // Sequencer: residue check, trials over the set in order, result hand-off.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         idx_ff       <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  resid_ff <= req_if.value;
                  if (req_if.restart_count) begin
                     total_ff <= '0;
                  end
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               idx_ff <= '0;
               if ((active == '0) || (resid_ff == '0)) begin
                  smooth_ff <= 1'b0;
                  state_ff  <= S_FINISH;
               end else if (resid_ff == VALUE_BITS'(1)) begin
                  smooth_ff <= 1'b1;
                  state_ff  <= S_FINISH;
               end else begin
                  state_ff <= S_TRY;
               end
            end
            S_TRY: begin
               if (idx_ff >= active) begin
                  smooth_ff <= 1'b0;
                  state_ff  <= S_FINISH;
               end else if (sel_prime < PRIME_MIN) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_stat.done) begin
                  if (div_stat.exact) begin
                     resid_ff <= quotient;
                     state_ff <= S_CHECK;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_TRY;
                  end
               end
            end
            S_FINISH: begin
               if (rsp_load) begin
                  rsp_smooth_ff <= smooth_ff;
                  rsp_count_ff  <= total_in;
                  total_ff      <= total_in;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready        = (state_ff == S_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.is_smooth    = rsp_smooth_ff;
   assign rsp_if.smooth_count = rsp_count_ff;

endmodule

// ===== rtl/snc_checker.sv =====
// Port-level checks for the smooth number checker, bound to the top level.
// Depends on the top level's interface ports and snc_pkg.
module snc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_is_smooth,
   input logic [snc_pkg::COUNT_BITS-1:0]  rsp_smooth_count
);
   import snc_pkg::*;

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smooth_count))
      else $error("result beat changed while stalled");

   // One item at a time: the block is busy straight after taking a beat.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again while an item was in work");

   // No result can appear in the cycle after an item is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // A smooth result always carries a count of at least one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_smooth |-> rsp_smooth_count != '0)
      else $error("smooth result with a zero count");

endmodule

bind smooth_number_checker_unit snc_checker u_snc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_is_smooth    (rsp_if.is_smooth),
   .rsp_smooth_count (rsp_if.smooth_count)
);
